>>> rtl/miu_pkg.sv
// shared types, op codes and constants of the integer execute unit
package miu_pkg;

    localparam int unsigned DataWidth     = 32;
    localparam int unsigned RegCount      = 32;
    localparam int unsigned RegIndexWidth = 5;
    localparam logic [31:0] TopMask       = 32'hF000_0000;
    localparam logic [4:0]  LinkReg       = 5'd31;

    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,  OP_ADDU  = 6'd1,  OP_ADDI  = 6'd2,  OP_ADDIU = 6'd3,
        OP_AND   = 6'd4,  OP_ANDI  = 6'd5,  OP_DIV   = 6'd6,  OP_DIVU  = 6'd7,
        OP_MULT  = 6'd8,  OP_MULTU = 6'd9,  OP_NOR   = 6'd10, OP_OR    = 6'd11,
        OP_ORI   = 6'd12, OP_SLL   = 6'd13, OP_SLLV  = 6'd14, OP_SRA   = 6'd15,
        OP_SRAV  = 6'd16, OP_SRL   = 6'd17, OP_SRLV  = 6'd18, OP_SUB   = 6'd19,
        OP_SUBU  = 6'd20, OP_XOR   = 6'd21, OP_XORI  = 6'd22, OP_LHI   = 6'd23,
        OP_LLO   = 6'd24, OP_SLT   = 6'd25, OP_SLTU  = 6'd26, OP_SLTI  = 6'd27,
        OP_SLTIU = 6'd28, OP_BEQ   = 6'd29, OP_BGTZ  = 6'd30, OP_BLEZ  = 6'd31,
        OP_BNE   = 6'd32, OP_J     = 6'd33, OP_JAL   = 6'd34, OP_JALR  = 6'd35,
        OP_JR    = 6'd36, OP_MFHI  = 6'd37, OP_MFLO  = 6'd38, OP_MTHI  = 6'd39,
        OP_MTLO  = 6'd40
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_OUT
    } state_t;

    // request and reply of the divide unit
    typedef struct packed {
        logic        start;
        logic        is_signed;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

>>> rtl/miu_ram.sv
// generic single write port, single read port ram with registered read
module miu_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/miu_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module miu_div
    import miu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic        busy_reg, busy_next;
    logic [5:0]  count_reg, count_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;
    logic [31:0] abs_a, abs_b;

    // operand magnitudes
    assign abs_a = (req.is_signed && req.dividend[31]) ? 32'(-req.dividend) : req.dividend;
    assign abs_b = (req.is_signed && req.divisor[31]) ? 32'(-req.divisor) : req.divisor;
    assign shifted = {rem_reg, quo_reg[31]};
    assign trial = shifted - {1'b0, dvs_reg};

    // iteration
    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        negq_next  = negq_reg;
        negr_next  = negr_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = 6'd0;
            rem_next   = '0;
            quo_next   = abs_a;
            dvs_next   = abs_b;
            negq_next  = req.is_signed && (req.dividend[31] ^ req.divisor[31]);
            negr_next  = req.is_signed && req.dividend[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            count_next = count_reg + 6'd1;
            if (count_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    // sign fixup of the result
    assign rsp.done      = done_reg;
    assign rsp.quotient  = negq_reg ? 32'(-quo_reg) : quo_reg;
    assign rsp.remainder = negr_reg ? 32'(-rem_reg) : rem_reg;
endmodule

>>> rtl/mips_integer_execute_unit.sv
// top level of the integer execute unit
// Executes one decoded integer instruction per input beat and returns one result beat.
// The register file is a 32x32 ram with a registered read, read twice per instruction
// (rs then rt). An accepted beat passes through the read and execute states to the
// result, and a new beat is taken only after the result beat has been accepted;
// mult/multu pass an extra state for the registered product, div/divu wait in the
// bit-serial divider until it is done. After reset a clearing pass writes zero to all
// 32 registers before the first beat is accepted. A cfg_we write loads the program counter.
module mips_integer_execute_unit
    import miu_pkg::*;
#(
    parameter int unsigned Regs = RegCount
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func, src_reg_a, src_reg_b, dst_reg, shift_amount, immediate, jump_index, pad
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // reg_written, written_index, written_value, next_address, overflow,
    // divide_by_zero, invalid_op, pad
    output logic [79:0]  m_tdata
);
    localparam int unsigned Aw = $clog2(Regs);

    state_t state_reg, state_next;
    logic [Aw:0] clr_reg, clr_next;
    logic [71:0] item_reg;
    logic [31:0] a_reg, pc_reg, hi_reg, lo_reg;
    logic [63:0] prod_reg;
    logic [79:0] res_reg;

    logic [5:0]  func;
    logic [4:0]  ra, rb, rd, sh;
    logic [15:0] imm;
    logic [25:0] jidx;

    logic        we;
    logic [Aw-1:0] waddr, raddr;
    logic [31:0] wdata, rdata, b;

    div_req_t dreq;
    div_rsp_t drsp;

    assign func = item_reg[5:0];
    assign ra   = item_reg[10:6];
    assign rb   = item_reg[15:11];
    assign rd   = item_reg[20:16];
    assign sh   = item_reg[25:21];
    assign imm  = item_reg[41:26];
    assign jidx = item_reg[67:42];
    assign b    = rdata;

    miu_ram #(.Width(DataWidth), .Depth(Regs)) u_rf (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    miu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // execute combinational result
    logic [31:0] simm, zimm, pc4, val, npc, r, sft;
    logic        wr, ovf, dz, bad, sethi, setlo;
    logic [31:0] nhi, nlo;
    logic [4:0]  dst, samt;
    logic [32:0] sraw;

    always_comb
    begin
        simm  = {{16{imm[15]}}, imm};
        zimm  = {16'd0, imm};
        pc4   = pc_reg + 32'd4;
        npc   = pc4;
        val   = '0;
        dst   = '0;
        wr    = 1'b0;
        ovf   = 1'b0;
        dz    = 1'b0;
        bad   = 1'b0;
        sethi = 1'b0;
        setlo = 1'b0;
        nhi   = hi_reg;
        nlo   = lo_reg;
        r     = '0;
        samt  = (func == OP_SLL || func == OP_SRL || func == OP_SRA) ? sh : a_reg[4:0];
        sraw  = $signed({b[31], b}) >>> samt;
        sft   = '0;
        unique case (func)
            OP_SLL, OP_SLLV: sft = b << samt;
            OP_SRL, OP_SRLV: sft = b >> samt;
            default:         sft = sraw[31:0];
        endcase
        unique case (func)
            OP_ADD:
            begin
                r = a_reg + b;
                ovf = (a_reg[31] == b[31]) && (r[31] != a_reg[31]);
                wr = !ovf; dst = rd; val = r;
            end
            OP_ADDU:  begin wr = 1'b1; dst = rd; val = a_reg + b; end
            OP_ADDI:
            begin
                r = a_reg + simm;
                ovf = (a_reg[31] == simm[31]) && (r[31] != a_reg[31]);
                wr = !ovf; dst = rb; val = r;
            end
            OP_ADDIU: begin wr = 1'b1; dst = rb; val = a_reg + simm; end
            OP_AND:   begin wr = 1'b1; dst = rd; val = a_reg & b; end
            OP_ANDI:  begin wr = 1'b1; dst = rb; val = a_reg & zimm; end
            OP_DIV, OP_DIVU:
            begin
                if (b == '0) dz = 1'b1;
                else
                begin
                    sethi = 1'b1; setlo = 1'b1;
                    nlo = drsp.quotient; nhi = drsp.remainder;
                end
            end
            OP_MULT, OP_MULTU:
            begin
                sethi = 1'b1; setlo = 1'b1;
                nlo = prod_reg[31:0]; nhi = prod_reg[63:32];
            end
            OP_NOR:   begin wr = 1'b1; dst = rd; val = ~(a_reg | b); end
            OP_OR:    begin wr = 1'b1; dst = rd; val = a_reg | b; end
            OP_ORI:   begin wr = 1'b1; dst = rb; val = a_reg | zimm; end
            OP_SLL, OP_SLLV, OP_SRA, OP_SRAV, OP_SRL, OP_SRLV:
            begin
                wr = 1'b1; dst = rd; val = sft;
            end
            OP_SUB:
            begin
                r = a_reg - b;
                ovf = (a_reg[31] != b[31]) && (r[31] != a_reg[31]);
                wr = !ovf; dst = rd; val = r;
            end
            OP_SUBU:  begin wr = 1'b1; dst = rd; val = a_reg - b; end
            OP_XOR:   begin wr = 1'b1; dst = rd; val = a_reg ^ b; end
            OP_XORI:  begin wr = 1'b1; dst = rb; val = a_reg ^ zimm; end
            OP_LHI:   begin sethi = 1'b1; nhi = zimm; end
            OP_LLO:   begin setlo = 1'b1; nlo = zimm; end
            OP_SLT:   begin wr = 1'b1; dst = rd; val = {31'd0, $signed(a_reg) < $signed(b)}; end
            OP_SLTU:  begin wr = 1'b1; dst = rd; val = {31'd0, a_reg < b}; end
            OP_SLTI:  begin wr = 1'b1; dst = rb; val = {31'd0, $signed(a_reg) < $signed(simm)}; end
            OP_SLTIU: begin wr = 1'b1; dst = rb; val = {31'd0, a_reg < simm}; end
            OP_BEQ:   if (a_reg == b) npc = pc4 + {simm[29:0], 2'b00};
            OP_BGTZ:  if ($signed(a_reg) > 0) npc = pc4 + {simm[29:0], 2'b00};
            OP_BLEZ:  if ($signed(a_reg) <= 0) npc = pc4 + {simm[29:0], 2'b00};
            OP_BNE:   if (a_reg != b) npc = pc4 + {simm[29:0], 2'b00};
            OP_J:     npc = (pc_reg & TopMask) | {4'd0, jidx, 2'b00};
            OP_JAL:
            begin
                wr = 1'b1; dst = LinkReg; val = pc4;
                npc = (pc_reg & TopMask) | {4'd0, jidx, 2'b00};
            end
            OP_JALR:  begin wr = 1'b1; dst = LinkReg; val = pc4; npc = a_reg; end
            OP_JR:    npc = a_reg;
            OP_MFHI:  begin wr = 1'b1; dst = rd; val = hi_reg; end
            OP_MFLO:  begin wr = 1'b1; dst = rd; val = lo_reg; end
            OP_MTHI:  begin sethi = 1'b1; nhi = a_reg; end
            OP_MTLO:  begin setlo = 1'b1; nlo = a_reg; end
            default:  begin bad = 1'b1; npc = pc_reg; end
        endcase
        if (!wr || dst == '0)
        begin
            wr = 1'b0; dst = '0; val = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (Aw+1)'(Regs - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:  if (s_tvalid) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (func == OP_MULT || func == OP_MULTU) state_next = ST_MUL;
                else if ((func == OP_DIV || func == OP_DIVU) && b != '0) state_next = ST_DIV;
                else state_next = ST_OUT;
            end
            ST_MUL:   state_next = ST_OUT;
            ST_DIV:   if (drsp.done) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and ram control
    logic commit;
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = res_reg;
        commit   = (state_reg == ST_EXEC && state_next == ST_OUT)
                || (state_reg == ST_MUL)
                || (state_reg == ST_DIV && drsp.done);
        raddr    = (state_reg == ST_IDLE) ? Aw'(s_tdata[10:6]) : Aw'(rb);
        we       = (state_reg == ST_CLEAR) || (commit && wr);
        waddr    = (state_reg == ST_CLEAR) ? clr_reg[Aw-1:0] : Aw'(dst);
        wdata    = (state_reg == ST_CLEAR) ? '0 : val;
        dreq.start     = (state_reg == ST_EXEC) && (func == OP_DIV || func == OP_DIVU)
                      && b != '0;
        dreq.is_signed = (func == OP_DIV);
        dreq.dividend  = a_reg;
        dreq.divisor   = b;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we) pc_reg <= cfg_wdata;
            else if (commit) pc_reg <= npc;
            if (commit && sethi) hi_reg <= nhi;
            if (commit && setlo) lo_reg <= nlo;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid) item_reg <= s_tdata;
        if (state_reg == ST_READ) a_reg <= rdata;
        if (state_reg == ST_EXEC)
        begin
            if (func == OP_MULT) prod_reg <= 64'($signed(a_reg) * $signed(b));
            else prod_reg <= {32'd0, a_reg} * {32'd0, b};
        end
        if (commit) res_reg <= {7'd0, bad, dz, ovf, npc, val, dst, wr};
    end
endmodule
